// ===== rtl/sha256c_pkg.sv =====
// shared types, constants and round functions of the sha-256 compression core
package sha256c_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned RoundW  = $clog2(Rounds);
  localparam int unsigned BlockWd = 16;
  localparam int unsigned WcntW   = $clog2(BlockWd);

  typedef logic [WordW-1:0]  word_t;
  typedef logic [7:0][WordW-1:0] hash_t;
  typedef logic [RoundW-1:0] round_t;

  // command word from the controller to the datapath
  typedef struct packed {
    logic   load_word;
    logic   restart_chain;
    logic   init_vars;
    logic   do_round;
    logic   update_chain;
    logic   load_digest;
    round_t round;
  } cmd_t;

  // element 0 is H0
  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== rtl/sha256c_if.sv =====
// valid/ready channel interfaces for message words and digests
interface sha256c_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic        new_message;
  logic        final_block;

  modport source (output valid, msg_word, new_message, final_block, input ready);
  modport sink   (input valid, msg_word, new_message, final_block, output ready);
endinterface

interface sha256c_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_hi;
  logic [63:0] digest_mid_hi;
  logic [63:0] digest_mid_lo;
  logic [63:0] digest_lo;

  modport source (output valid, digest_hi, digest_mid_hi, digest_mid_lo, digest_lo,
                  input ready);
  modport sink   (input valid, digest_hi, digest_mid_hi, digest_mid_lo, digest_lo,
                  output ready);
endinterface

// ===== rtl/sha256c_ctrl.sv =====
// controller: word counting, round sequencing and digest hand-off
module sha256c_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              new_message_i,
  input  logic              final_block_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output sha256c_pkg::cmd_t cmd_o
);
  import sha256c_pkg::*;

  localparam logic [1:0] StLoad   = 2'd0;
  localparam logic [1:0] StRound  = 2'd1;
  localparam logic [1:0] StUpdate = 2'd2;
  localparam logic [1:0] StEmit   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [WcntW-1:0] wcnt_q, wcnt_d;
  round_t           round_q, round_d;
  logic             fin_q, fin_d;
  logic             out_valid_q, out_valid_d;

  logic             accept;
  logic [WcntW-1:0] word_idx;
  logic             last_word;
  logic             slot_free;

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  // a new message drops any partly filled block
  assign word_idx    = new_message_i ? '0 : wcnt_q;
  assign last_word   = (word_idx == WcntW'(BlockWd - 1));
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    wcnt_d  = wcnt_q;
    round_d = round_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.round = round_q;
    unique case (state_q)
      StLoad: begin
        if (accept) begin
          cmd_o.load_word     = 1'b1;
          cmd_o.restart_chain = new_message_i;
          wcnt_d = word_idx + 1'b1;
          fin_d  = (new_message_i ? 1'b0 : fin_q) | final_block_i;
          if (last_word) begin
            cmd_o.init_vars = 1'b1;
            round_d = '0;
            state_d = StRound;
          end
        end
      end
      StRound: begin
        cmd_o.do_round = 1'b1;
        round_d = round_q + 1'b1;
        if (round_q == RoundW'(Rounds - 1)) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update_chain = 1'b1;
        fin_d   = 1'b0;
        state_d = fin_q ? StEmit : StLoad;
      end
      StEmit: begin
        if (slot_free) begin
          cmd_o.load_digest = 1'b1;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_comb begin
    if (cmd_o.load_digest) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      wcnt_q      <= '0;
      round_q     <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      round_q     <= round_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/sha256c_dp.sv =====
// datapath: schedule window, working variables, chaining value and digest register
module sha256c_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha256c_pkg::cmd_t  cmd_i,
  input  sha256c_pkg::word_t msg_word_i,
  output sha256c_pkg::hash_t digest_o
);
  import sha256c_pkg::*;

  word_t window_q [BlockWd];
  hash_t vars_q;
  hash_t chain_q;
  hash_t digest_q;

  word_t w_next, shift_in, t1, t2, choose, major;
  logic  shift_en;

  // window holds w[r..r+15]; tap 0 feeds the current round
  assign w_next = small_sigma1(window_q[14]) + window_q[9]
                + small_sigma0(window_q[1]) + window_q[0];
  assign shift_in = cmd_i.load_word ? msg_word_i : w_next;
  assign shift_en = cmd_i.load_word || cmd_i.do_round;

  assign choose = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign major  = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2])
                ^ (vars_q[1] & vars_q[2]);
  assign t1 = vars_q[7] + big_sigma1(vars_q[4]) + choose + RoundK[cmd_i.round] + window_q[0];
  assign t2 = big_sigma0(vars_q[0]) + major;

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < BlockWd - 1; i++) begin
        window_q[i] <= window_q[i+1];
      end
      window_q[BlockWd-1] <= shift_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_vars) begin
      vars_q <= chain_q;
    end else if (cmd_i.do_round) begin
      vars_q[7] <= vars_q[6];
      vars_q[6] <= vars_q[5];
      vars_q[5] <= vars_q[4];
      vars_q[4] <= vars_q[3] + t1;
      vars_q[3] <= vars_q[2];
      vars_q[2] <= vars_q[1];
      vars_q[1] <= vars_q[0];
      vars_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitHash;
    end else if (cmd_i.restart_chain) begin
      chain_q <= InitHash;
    end else if (cmd_i.update_chain) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_q[i] + vars_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_digest) begin
      digest_q <= chain_q;
    end
  end

  assign digest_o = digest_q;

endmodule

// ===== rtl/sha256_block_compression_core.sv =====
// top level of the sha-256 block compression core
//
// The input channel carries one 32-bit big-endian word of an already padded
// message per transfer, sixteen to a block. new_message on a word restarts the
// chain from the standard initial hash and makes that word the first of a block;
// final_block on any word of a block marks the block as the message's last.
// The input is ready while words are being collected. After the sixteenth word
// the core runs 64 rounds, one a cycle, then adds the working variables into
// the chaining value. For a final block the digest is then moved into the
// output register, which holds it until it is taken; the core keeps collecting
// the next words meanwhile. Only when a further digest is ready while the
// previous one is still waiting does the core hold, with input not ready,
// until the output transfer. Reset loads the initial hash, clears the word
// position and final mark and leaves the output empty.
module sha256_block_compression_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha256c_in_if.sink    in_i,
  sha256c_out_if.source out_o
);
  import sha256c_pkg::*;

  cmd_t  cmd;
  hash_t digest;

  sha256c_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .new_message_i (in_i.new_message),
    .final_block_i (in_i.final_block),
    .in_ready_o    (in_i.ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .cmd_o         (cmd)
  );

  sha256c_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .msg_word_i (in_i.msg_word),
    .digest_o   (digest)
  );

  assign out_o.digest_hi     = {digest[0], digest[1]};
  assign out_o.digest_mid_hi = {digest[2], digest[3]};
  assign out_o.digest_mid_lo = {digest[4], digest[5]};
  assign out_o.digest_lo     = {digest[6], digest[7]};

`ifndef SYNTHESIS
  // no word is taken while rounds are running
  a_no_input_in_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_round |-> !in_i.ready)
    else $error("input ready during rounds");

  // a pending digest is never overwritten
  a_no_digest_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_digest |-> (!out_o.valid || out_o.ready))
    else $error("digest overwritten before transfer");

  // the chain update follows the last round directly
  a_update_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update_chain |-> ($past(cmd.do_round) && $past(cmd.round) == RoundW'(Rounds - 1)))
    else $error("chain update without completed rounds");

  // the last round is always followed by the chain update
  a_rounds_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.do_round && cmd.round == RoundW'(Rounds - 1)) |=> cmd.update_chain)
    else $error("rounds ended without chain update");
`endif

endmodule
